@@ hdl/hpa_pkg.sv @@
// Package for the handle pool allocator: pool constants, codes and item types.
// It depends on nothing; the allocator, the checker and the testbench refer to it by scoped names.
package hpa_pkg;

    localparam int POOL_SIZE = 256;
    localparam int ADDR_W    = $clog2(POOL_SIZE);
    localparam int CNT_W     = $clog2(POOL_SIZE + 1);
    localparam int ACTION_W  = 2;
    localparam int STATUS_W  = 2;
    localparam int HANDLE_W  = 8;

    localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_TRY   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_FREE  = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NONE      = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EXHAUSTED = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_INVALID   = 2'd3;

    typedef enum logic [1:0] {
        FSM_CLEAR,
        FSM_IDLE,
        FSM_EXEC
    } fsm_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [HANDLE_W-1:0] handle_in;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] handle_out;
    } rsp_t;

endpackage

@@ hdl/hpa_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// It depends on nothing; the allocator uses it for the free list and the in-use marks.
module hpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hdl/handle_pool_allocator.sv @@
// Top level of the handle pool allocator: control, pointers and the two memories.
// It depends on hpa_pkg and hpa_ram.
//
// An item is accepted when start is high and busy is low, and the memories are read at
// that edge; in the EXEC state that follows, the block decides, writes back and registers
// the result, which appears on result with done high for one cycle after that. The
// registered read of the free-list and in-use memories is why the EXEC state is needed;
// busy stays high in EXEC, so a new item is accepted only once the last one is decided.
// After reset the block is busy while it clears all 256 entries of the in-use memory,
// one entry a cycle. The receiver cannot stall, so done is never held off.
module handle_pool_allocator (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  hpa_pkg::req_t request,
    output logic          done,
    output hpa_pkg::rsp_t result
);

    hpa_pkg::fsm_t state_reg, state_next;

    logic [hpa_pkg::ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [hpa_pkg::ADDR_W-1:0] head_reg, head_next;
    logic [hpa_pkg::ADDR_W-1:0] tail_reg, tail_next;
    logic [hpa_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [hpa_pkg::CNT_W-1:0]  fresh_reg, fresh_next;
    hpa_pkg::req_t              req_reg;
    hpa_pkg::rsp_t              rsp_reg, rsp_next;
    logic                       done_reg, done_next;

    logic                       accept;
    logic                       exec;
    logic                       clearing;
    logic                       clr_last;
    logic                       have_free;
    logic                       do_pop;
    logic                       do_fresh;
    logic                       do_free;
    logic                       in_range;

    logic                       mark_we;
    logic [hpa_pkg::ADDR_W-1:0] mark_waddr;
    logic                       mark_wdata;
    logic                       mark_rdata;
    logic [hpa_pkg::ADDR_W-1:0] list_rdata;

    function automatic logic [hpa_pkg::ADDR_W-1:0] clr_head(
        input logic [hpa_pkg::ADDR_W-1:0] pos
    );
        if (pos == hpa_pkg::ADDR_W'(hpa_pkg::POOL_SIZE - 1))
        begin
            return '0;
        end
        return pos + 1'b1;
    endfunction

    assign accept   = start && !busy;
    assign clr_last = (clr_cnt_reg == hpa_pkg::ADDR_W'(hpa_pkg::POOL_SIZE - 1));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hpa_pkg::FSM_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = hpa_pkg::FSM_IDLE;
                end
            end
            hpa_pkg::FSM_IDLE:
            begin
                if (start)
                begin
                    state_next = hpa_pkg::FSM_EXEC;
                end
            end
            hpa_pkg::FSM_EXEC:
            begin
                state_next = hpa_pkg::FSM_IDLE;
            end
            default:
            begin
                state_next = hpa_pkg::FSM_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        busy     = 1'b1;
        exec     = 1'b0;
        clearing = 1'b0;
        case (state_reg)
            hpa_pkg::FSM_CLEAR:
            begin
                clearing = 1'b1;
            end
            hpa_pkg::FSM_IDLE:
            begin
                busy = 1'b0;
            end
            hpa_pkg::FSM_EXEC:
            begin
                exec = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    assign have_free = (count_reg != '0);
    assign in_range  = ({1'b0, req_reg.handle_in} < 9'(hpa_pkg::POOL_SIZE));
    assign do_pop    = exec && have_free
                       && (req_reg.action == hpa_pkg::ACT_ALLOC
                           || req_reg.action == hpa_pkg::ACT_TRY);
    assign do_fresh  = exec && !have_free && (req_reg.action == hpa_pkg::ACT_ALLOC)
                       && (fresh_reg < hpa_pkg::CNT_W'(hpa_pkg::POOL_SIZE));
    assign do_free   = exec && (req_reg.action == hpa_pkg::ACT_FREE) && in_range && mark_rdata;

    always_comb
    begin
        mark_we    = 1'b0;
        mark_waddr = clr_cnt_reg;
        mark_wdata = 1'b0;
        if (clearing)
        begin
            mark_we = 1'b1;
        end
        else if (do_pop)
        begin
            mark_we    = 1'b1;
            mark_waddr = list_rdata;
            mark_wdata = 1'b1;
        end
        else if (do_fresh)
        begin
            mark_we    = 1'b1;
            mark_waddr = fresh_reg[hpa_pkg::ADDR_W-1:0];
            mark_wdata = 1'b1;
        end
        else if (do_free)
        begin
            mark_we    = 1'b1;
            mark_waddr = req_reg.handle_in[hpa_pkg::ADDR_W-1:0];
        end
    end

    always_comb
    begin
        clr_cnt_next = clearing ? clr_cnt_reg + 1'b1 : clr_cnt_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        fresh_next   = fresh_reg;
        rsp_next     = '0;
        done_next    = exec;

        if (do_pop)
        begin
            head_next  = clr_head(head_reg);
            count_next = count_reg - 1'b1;
        end
        if (do_fresh)
        begin
            fresh_next = fresh_reg + 1'b1;
        end
        if (do_free)
        begin
            tail_next  = clr_head(tail_reg);
            count_next = count_reg + 1'b1;
        end

        if (do_pop)
        begin
            rsp_next.status     = hpa_pkg::STAT_OK;
            rsp_next.handle_out = hpa_pkg::HANDLE_W'(list_rdata);
        end
        else if (do_fresh)
        begin
            rsp_next.status     = hpa_pkg::STAT_OK;
            rsp_next.handle_out = fresh_reg[hpa_pkg::HANDLE_W-1:0];
        end
        else if (do_free)
        begin
            rsp_next.status = hpa_pkg::STAT_OK;
        end
        else if (req_reg.action == hpa_pkg::ACT_ALLOC)
        begin
            rsp_next.status = hpa_pkg::STAT_EXHAUSTED;
        end
        else if (req_reg.action == hpa_pkg::ACT_TRY)
        begin
            rsp_next.status = hpa_pkg::STAT_NONE;
        end
        else
        begin
            rsp_next.status = hpa_pkg::STAT_INVALID;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= hpa_pkg::FSM_CLEAR;
            clr_cnt_reg <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            fresh_reg   <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            fresh_reg   <= fresh_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= request;
        end
        if (exec)
        begin
            rsp_reg <= rsp_next;
        end
    end

    hpa_ram #(
        .WIDTH (hpa_pkg::ADDR_W),
        .DEPTH (hpa_pkg::POOL_SIZE)
    ) u_free_list (
        .clk   (clk),
        .we    (do_free),
        .waddr (tail_reg),
        .wdata (req_reg.handle_in[hpa_pkg::ADDR_W-1:0]),
        .re    (accept),
        .raddr (head_reg),
        .rdata (list_rdata)
    );

    hpa_ram #(
        .WIDTH (1),
        .DEPTH (hpa_pkg::POOL_SIZE)
    ) u_in_use (
        .clk   (clk),
        .we    (mark_we),
        .waddr (mark_waddr),
        .wdata (mark_wdata),
        .re    (accept),
        .raddr (request.handle_in[hpa_pkg::ADDR_W-1:0]),
        .rdata (mark_rdata)
    );

    assign done   = done_reg;
    assign result = rsp_reg;

endmodule

@@ verif/hpa_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the handle pool allocator: it predicts every accepted item
// and compares each result.
// It depends on hpa_pkg and is instantiated beside the block by handle_pool_allocator_tb.
module hpa_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          busy,
    input  hpa_pkg::req_t request,
    input  logic          done,
    input  hpa_pkg::rsp_t result,
    output int            errors,
    output int            pending,
    output int            checked,
    output int            reused_grants,
    output int            exhausted_answers
);

    logic [hpa_pkg::ADDR_W-1:0]    freed_fifo [hpa_pkg::POOL_SIZE];
    logic [hpa_pkg::ADDR_W-1:0]    fifo_rd;
    logic [hpa_pkg::ADDR_W-1:0]    fifo_wr;
    logic [hpa_pkg::CNT_W-1:0]     fifo_count;
    logic [hpa_pkg::POOL_SIZE-1:0] in_use;
    logic [hpa_pkg::CNT_W-1:0]     fresh_handle;
    hpa_pkg::rsp_t                 expected_rsp [$];
    int                            err_count;
    int                            chk_count;
    int                            reuse_count;
    int                            exhaust_count;

    function automatic logic [hpa_pkg::ADDR_W-1:0] wrap_inc(
        input logic [hpa_pkg::ADDR_W-1:0] pos
    );
        return (pos == hpa_pkg::ADDR_W'(hpa_pkg::POOL_SIZE - 1)) ? '0 : pos + 1'b1;
    endfunction

    function automatic hpa_pkg::rsp_t predict_grant(input hpa_pkg::req_t item);
        hpa_pkg::rsp_t rsp;
        logic [hpa_pkg::ADDR_W-1:0] h;
        rsp = '0;
        case (item.action)
            hpa_pkg::ACT_ALLOC, hpa_pkg::ACT_TRY:
            begin
                if (fifo_count != 0)
                begin
                    h = freed_fifo[fifo_rd];
                    rsp.status = hpa_pkg::STAT_OK;
                    rsp.handle_out = hpa_pkg::HANDLE_W'(h);
                    in_use[h] = 1'b1;
                    fifo_rd = wrap_inc(fifo_rd);
                    fifo_count = fifo_count - 1'b1;
                    reuse_count++;
                end
                else if (item.action == hpa_pkg::ACT_TRY)
                begin
                    rsp.status = hpa_pkg::STAT_NONE;
                end
                else if (fresh_handle < hpa_pkg::POOL_SIZE)
                begin
                    rsp.status = hpa_pkg::STAT_OK;
                    rsp.handle_out = hpa_pkg::HANDLE_W'(fresh_handle);
                    in_use[fresh_handle[hpa_pkg::ADDR_W-1:0]] = 1'b1;
                    fresh_handle = fresh_handle + 1'b1;
                end
                else
                begin
                    rsp.status = hpa_pkg::STAT_EXHAUSTED;
                    exhaust_count++;
                end
            end
            hpa_pkg::ACT_FREE:
            begin
                if (int'(item.handle_in) < hpa_pkg::POOL_SIZE && in_use[item.handle_in])
                begin
                    in_use[item.handle_in] = 1'b0;
                    freed_fifo[fifo_wr] = hpa_pkg::ADDR_W'(item.handle_in);
                    fifo_wr = wrap_inc(fifo_wr);
                    fifo_count = fifo_count + 1'b1;
                    rsp.status = hpa_pkg::STAT_OK;
                end
                else
                begin
                    rsp.status = hpa_pkg::STAT_INVALID;
                end
            end
            default:
            begin
                rsp.status = hpa_pkg::STAT_INVALID;
            end
        endcase
        return rsp;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        hpa_pkg::rsp_t want;
        if (!rst_n)
        begin
            fifo_rd = '0;
            fifo_wr = '0;
            fifo_count = '0;
            in_use = '0;
            fresh_handle = '0;
            expected_rsp.delete();
            err_count = 0;
            chk_count = 0;
            reuse_count = 0;
            exhaust_count = 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_rsp.size() == 0)
                begin
                    err_count++;
                    $display("%0t: result with no item outstanding: status %0d handle %0d",
                             $time, result.status, result.handle_out);
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    chk_count++;
                    if (result.status !== want.status)
                    begin
                        err_count++;
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want.status, result.status);
                    end
                    if (result.handle_out !== want.handle_out)
                    begin
                        err_count++;
                        $display("%0t: handle_out mismatch: expected %0d, actual %0d",
                                 $time, want.handle_out, result.handle_out);
                    end
                end
            end
            if (start && !busy)
            begin
                expected_rsp.push_back(predict_grant(request));
            end
        end
        errors <= err_count;
        pending <= expected_rsp.size();
        checked <= chk_count;
        reused_grants <= reuse_count;
        exhausted_answers <= exhaust_count;
    end

endmodule

@@ verif/handle_pool_allocator_tb.sv @@
`timescale 1ns / 1ps
// Top of the handle pool allocator testbench: clock, reset, request stimulus and the verdict.
// It depends on hpa_pkg, handle_pool_allocator and the hpa_checker scoreboard.
module handle_pool_allocator_tb;

    localparam logic [hpa_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int IDLE_LIMIT = 4000;
    localparam int RANDOM_ITEMS = 1000;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic done;
    hpa_pkg::req_t request;
    hpa_pkg::rsp_t result;

    int errors;
    int pending;
    int checked;
    int reused_grants;
    int exhausted_answers;
    int sent;
    int quiet_cycles;
    bit calm;
    logic [hpa_pkg::ACTION_W-1:0] inflight_actions [$];
    logic [hpa_pkg::HANDLE_W-1:0] held_handles [$];
    logic [hpa_pkg::HANDLE_W-1:0] last_freed;

    handle_pool_allocator u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    hpa_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .request           (request),
        .done              (done),
        .result            (result),
        .errors            (errors),
        .pending           (pending),
        .checked           (checked),
        .reused_grants     (reused_grants),
        .exhausted_answers (exhausted_answers)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        logic [hpa_pkg::ACTION_W-1:0] act;
        if (rst_n)
        begin
            if (done && inflight_actions.size() != 0)
            begin
                act = inflight_actions.pop_front();
                if (act != hpa_pkg::ACT_FREE && result.status == hpa_pkg::STAT_OK)
                begin
                    held_handles.push_back(result.handle_out);
                end
            end
            if (start && !busy)
            begin
                inflight_actions.push_back(request.action);
            end
        end
        if ((start && !busy) || done)
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("Watchdog expired at %0t with %0d items outstanding.", $time, pending);
            $display("handle_pool_allocator test failed");
            $finish;
        end
    end

    task automatic issue(input logic [hpa_pkg::ACTION_W-1:0] act,
                         input logic [hpa_pkg::HANDLE_W-1:0] h);
        request <= '{action: act, handle_in: h};
        start <= 1'b1;
        do @(posedge clk); while (busy);
        sent++;
        if (act == hpa_pkg::ACT_FREE)
        begin
            last_freed = h;
        end
    endtask

    task automatic maybe_pause();
        int gap;
        if (!calm && $urandom_range(99) < 12)
        begin
            gap = $urandom_range(4, 1);
            start <= 1'b0;
            request <= hpa_pkg::req_t'($urandom);
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic random_item(input int alloc_pct, input int free_pct);
        int roll;
        int idx;
        logic [hpa_pkg::HANDLE_W-1:0] h;
        roll = $urandom_range(99);
        if (roll < alloc_pct)
        begin
            issue(hpa_pkg::ACT_ALLOC, hpa_pkg::HANDLE_W'($urandom));
        end
        else if (roll < alloc_pct + free_pct && held_handles.size() != 0)
        begin
            idx = $urandom_range(held_handles.size() - 1);
            h = held_handles[idx];
            held_handles.delete(idx);
            issue(hpa_pkg::ACT_FREE, h);
        end
        else
        begin
            case ($urandom_range(3))
                0: issue(hpa_pkg::ACT_TRY, hpa_pkg::HANDLE_W'($urandom));
                1: issue(hpa_pkg::ACT_FREE, hpa_pkg::HANDLE_W'($urandom));
                2: issue(ACT_UNUSED, hpa_pkg::HANDLE_W'($urandom));
                default: issue(hpa_pkg::ACT_FREE, last_freed);
            endcase
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        sent = 0;
        calm = 1'b0;
        last_freed = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Empty pool, never-issued handles and the unused action code first.
        issue(hpa_pkg::ACT_TRY, 8'hFF);
        issue(hpa_pkg::ACT_FREE, 8'h00);
        issue(hpa_pkg::ACT_FREE, 8'hFF);
        issue(ACT_UNUSED, 8'hFF);
        issue(ACT_UNUSED, 8'h00);
        issue(hpa_pkg::ACT_ALLOC, 8'hFF);
        issue(hpa_pkg::ACT_ALLOC, 8'h00);
        issue(hpa_pkg::ACT_ALLOC, 8'h55);
        issue(hpa_pkg::ACT_FREE, 8'h01);
        issue(hpa_pkg::ACT_FREE, 8'h01);
        issue(hpa_pkg::ACT_FREE, 8'h00);
        issue(hpa_pkg::ACT_TRY, 8'h00);
        issue(hpa_pkg::ACT_ALLOC, 8'h00);
        issue(hpa_pkg::ACT_TRY, 8'hAA);
        issue(hpa_pkg::ACT_FREE, 8'h02);
        issue(hpa_pkg::ACT_ALLOC, 8'h00);
        issue(hpa_pkg::ACT_FREE, 8'hAA);
        issue(hpa_pkg::ACT_ALLOC, 8'h00);

        // Fill the pool past exhaustion, drain it, then run a balanced mix.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            calm = (n >= 650 && n < 900);
            maybe_pause();
            if (n < 340)
            begin
                random_item(92, 4);
            end
            else if (n < 640)
            begin
                random_item(8, 85);
            end
            else
            begin
                random_item(45, 45);
            end
        end
        start <= 1'b0;

        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
        $display("Sent %0d requests and checked %0d results, including %0d reused grants",
                 sent, checked, reused_grants);
        $display("and %0d exhausted answers, with random idle gaps on the request side.",
                 exhausted_answers);
        if (errors == 0 && pending == 0)
        begin
            $display("handle_pool_allocator test passed");
        end
        else
        begin
            $display("handle_pool_allocator test failed");
        end
        $finish;
    end

endmodule
